// ===== rtl/core/bxavg_pkg.sv =====
// Shared constants and types for the box-average downscaler.
// No dependencies; every other file of the block uses this package.
package bxavg_pkg;

	// Default sizing handed to the top-level parameters
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_FACTOR_DEF = 16;

	// Frame height bound and the row counter that covers it
	localparam int HEIGHT_LIMIT = 2048;
	localparam int ROW_W        = $clog2(HEIGHT_LIMIT);

	// Field widths
	localparam int PIX_W = 8;
	localparam int AVG_W = 8;

	// Configuration registers
	localparam int WIDTH_REG_W  = 12;
	localparam int HEIGHT_REG_W = 12;
	localparam int FACTOR_REG_W = 5;
	localparam int CFG_DATA_W   = 12;
	localparam int CFG_IDX_W    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 2'd2;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd480;
	localparam logic [FACTOR_REG_W-1:0] FACTOR_RESET = 5'd2;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Classification of one accepted pixel
	typedef struct packed {
		logic col_first;  // first pixel of a block row
		logic col_last;   // last pixel of a block row
		logic row_fresh;  // top row of the block: start the column sum over
		logic row_last;   // bottom row of the block: the block completes here
		logic row_end;    // block is the last full one of its output row
		logic frame_end;  // ... and lies in the last full block row
	} cmd_flags_t;

	// Marks carried along with a result
	typedef struct packed {
		logic frame_end;
		logic row_end;
	} out_tag_t;

endpackage

// ===== rtl/core/bxavg_front.sv =====
// Front end: configuration registers, frame position counters and pixel classification.
// Depends on bxavg_pkg.
module bxavg_front #(
	parameter int MAX_WIDTH  = bxavg_pkg::MAX_WIDTH_DEF,
	parameter int MAX_FACTOR = bxavg_pkg::MAX_FACTOR_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [bxavg_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bxavg_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                   pix_valid,
	output logic                                   pix_ready,
	input  logic [bxavg_pkg::PIX_W-1:0]            pixel,
	input  logic                                   q_full,
	output logic                                   push,
	output logic [bxavg_pkg::PIX_W-1:0]            push_pixel,
	output logic [$clog2(MAX_WIDTH)-1:0]           push_col,
	output bxavg_pkg::cmd_flags_t                  push_flags,
	output logic [2*$clog2(MAX_FACTOR+1)-1:0]      divisor
);
	import bxavg_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int FACT_W = $clog2(MAX_FACTOR + 1);
	localparam int PH_W   = $clog2(MAX_FACTOR);
	localparam int DIV_W  = 2 * FACT_W;
	localparam int CW     = ((COL_W > FACT_W + 1) ? COL_W : FACT_W + 1) + 2;
	localparam int RW     = ((ROW_W > FACT_W + 1) ? ROW_W : FACT_W + 1) + 2;

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [FACTOR_REG_W-1:0] factor_q;

	logic [ROW_W-1:0] row_cnt_q;
	logic [ROW_W-1:0] blk_top_q;
	logic [PH_W-1:0]  row_ph_q;
	logic [COL_W-1:0] col_cnt_q;
	logic [COL_W-1:0] blk_left_q;
	logic [COL_W-1:0] out_col_q;
	logic [PH_W-1:0]  col_ph_q;
	logic [DIV_W-1:0] divisor_q;

	logic [CW-1:0]     w_eff;
	logic [RW-1:0]     h_eff;
	logic [FACT_W-1:0] n_eff;
	logic [CW-1:0]     n_cw;
	logic [RW-1:0]     n_rw;
	logic [PH_W-1:0]   n_m1;
	logic              full_col;
	logic              full_row;
	logic              col_last;
	logic              row_last;
	logic              col_wrap;
	logic              row_wrap;
	logic              last_blk_col;
	logic              last_blk_row;
	logic              accept;
	logic              restart;

	// Clamp the registers to their working range
	always_comb begin
		if (width_q == '0) begin
			w_eff = CW'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = RW'(1);
		end else if (int'(height_q) > HEIGHT_LIMIT) begin
			h_eff = RW'(HEIGHT_LIMIT);
		end else begin
			h_eff = RW'(height_q);
		end
		if (factor_q == '0) begin
			n_eff = FACT_W'(1);
		end else if (int'(factor_q) > MAX_FACTOR) begin
			n_eff = FACT_W'(MAX_FACTOR);
		end else begin
			n_eff = FACT_W'(factor_q);
		end
	end

	// Classify the current position against the block grid
	assign n_cw         = CW'(n_eff);
	assign n_rw         = RW'(n_eff);
	assign n_m1         = PH_W'(n_eff - 1'b1);
	assign full_col     = (CW'(blk_left_q) + n_cw) <= w_eff;
	assign full_row     = (RW'(blk_top_q) + n_rw) <= h_eff;
	assign last_blk_col = (CW'(blk_left_q) + (n_cw << 1)) > w_eff;
	assign last_blk_row = (RW'(blk_top_q) + (n_rw << 1)) > h_eff;
	assign col_last     = col_ph_q == n_m1;
	assign row_last     = row_ph_q == n_m1;
	assign col_wrap     = CW'(col_cnt_q) == (w_eff - 1'b1);
	assign row_wrap     = RW'(row_cnt_q) == (h_eff - 1'b1);

	assign pix_ready = !q_full;
	assign accept    = pix_valid && pix_ready;

	// Forward only pixels that fall inside a whole block
	assign push                  = accept && full_col && full_row;
	assign push_pixel            = pixel;
	assign push_col              = out_col_q;
	assign push_flags.col_first  = col_ph_q == '0;
	assign push_flags.col_last   = col_last;
	assign push_flags.row_fresh  = row_ph_q == '0;
	assign push_flags.row_last   = row_last;
	assign push_flags.row_end    = last_blk_col;
	assign push_flags.frame_end  = last_blk_col && last_blk_row;
	assign divisor               = divisor_q;

	// Decode configuration writes
	always_comb begin
		unique case (cfg_index)
			REG_WIDTH, REG_HEIGHT, REG_FACTOR: restart = cfg_we;
			default:                           restart = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			factor_q <= FACTOR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
				REG_FACTOR: factor_q <= cfg_data[FACTOR_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance the frame position on every accepted word; restart on a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q  <= '0;
			blk_top_q  <= '0;
			row_ph_q   <= '0;
			col_cnt_q  <= '0;
			blk_left_q <= '0;
			out_col_q  <= '0;
			col_ph_q   <= '0;
		end else if (restart) begin
			row_cnt_q  <= '0;
			blk_top_q  <= '0;
			row_ph_q   <= '0;
			col_cnt_q  <= '0;
			blk_left_q <= '0;
			out_col_q  <= '0;
			col_ph_q   <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_cnt_q  <= '0;
				col_ph_q   <= '0;
				out_col_q  <= '0;
				blk_left_q <= '0;
				if (row_wrap) begin
					row_cnt_q <= '0;
					row_ph_q  <= '0;
					blk_top_q <= '0;
				end else begin
					row_cnt_q <= row_cnt_q + 1'b1;
					if (row_last) begin
						row_ph_q  <= '0;
						blk_top_q <= blk_top_q + ROW_W'(n_eff);
					end else begin
						row_ph_q <= row_ph_q + 1'b1;
					end
				end
			end else begin
				col_cnt_q <= col_cnt_q + 1'b1;
				if (col_last) begin
					col_ph_q   <= '0;
					out_col_q  <= out_col_q + 1'b1;
					blk_left_q <= blk_left_q + COL_W'(n_eff);
				end else begin
					col_ph_q <= col_ph_q + 1'b1;
				end
			end
		end
	end

	// Block area for the divider
	always_ff @(posedge clk) begin
		divisor_q <= DIV_W'(n_eff) * DIV_W'(n_eff);
	end

endmodule

// ===== rtl/core/bxavg_queue.sv =====
// Short register queue that decouples the front end from the accumulator.
// Depends on bxavg_pkg only for the default depth; width and depth come in as parameters.
module bxavg_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = bxavg_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              pop_valid,
	output logic [DATA_W-1:0] pop_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full      = cnt_q == CNT_W'(DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_data  = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Move the pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/bxavg_div.sv =====
// Pipelined restoring divider: block sum by block area, one quotient bit per stage.
// Depends on bxavg_pkg for the result tag type.
module bxavg_div #(
	parameter int SUM_W = 16,
	parameter int DIV_W = 10,
	parameter int QW    = bxavg_pkg::AVG_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [SUM_W-1:0]      dividend,
	input  logic [DIV_W-1:0]      divisor,
	input  bxavg_pkg::out_tag_t   in_tag,
	output logic                  out_valid,
	output logic [QW-1:0]         quotient,
	output bxavg_pkg::out_tag_t   out_tag
);
	import bxavg_pkg::*;

	localparam int TW = DIV_W + QW;

	logic             vld_s [QW+1];
	logic [SUM_W-1:0] rem_s [QW+1];
	logic [QW-1:0]    quo_s [QW+1];
	out_tag_t         tag_s [QW+1];

	// Capture the dividend
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= dividend;
			quo_s[0] <= '0;
			tag_s[0] <= in_tag;
		end
	end

	// One compare and subtract per stage, most significant quotient bit first
	for (genvar k = 1; k <= QW; k++) begin : g_step
		localparam int B = QW - k;
		logic [TW-1:0] shifted;
		logic [TW-1:0] trial;
		logic          fits;

		assign shifted = TW'(divisor) << B;
		assign fits    = TW'(rem_s[k-1]) >= shifted;
		assign trial   = TW'(rem_s[k-1]) - shifted;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= fits ? SUM_W'(trial) : rem_s[k-1];
				quo_s[k] <= quo_s[k-1] | (QW'(fits) << B);
				tag_s[k] <= tag_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign quotient  = quo_s[QW];
	assign out_tag   = tag_s[QW];

endmodule

// ===== rtl/core/bxavg_back.sv =====
// Back end: row sums, line accumulator memory, divider and the result register.
// Depends on bxavg_pkg and bxavg_div.
module bxavg_back #(
	parameter int MAX_WIDTH  = bxavg_pkg::MAX_WIDTH_DEF,
	parameter int MAX_FACTOR = bxavg_pkg::MAX_FACTOR_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  logic [bxavg_pkg::PIX_W-1:0]       q_pixel,
	input  logic [$clog2(MAX_WIDTH)-1:0]      q_col,
	input  bxavg_pkg::cmd_flags_t             q_flags,
	output logic                              q_pop,
	input  logic [2*$clog2(MAX_FACTOR+1)-1:0] divisor,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [bxavg_pkg::AVG_W-1:0]       res_avg,
	output bxavg_pkg::out_tag_t               res_tag
);
	import bxavg_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int DIV_W  = 2 * $clog2(MAX_FACTOR + 1);
	localparam int HSUM_W = PIX_W + $clog2(MAX_FACTOR);
	localparam int SUM_W  = PIX_W + 2 * $clog2(MAX_FACTOR);

	logic [SUM_W-1:0]  sums_mem [MAX_WIDTH];

	logic              adv;
	logic              take;
	logic [HSUM_W-1:0] hsum_q;
	logic [HSUM_W-1:0] hsum_new;

	logic              vld_s1;
	logic [HSUM_W-1:0] hsum_s1;
	logic [COL_W-1:0]  col_s1;
	logic              fresh_s1;
	logic              emit_s1;
	out_tag_t          tag_s1;

	logic [SUM_W-1:0]  rd_q;
	logic [SUM_W-1:0]  wr_q;
	logic              fwd_q;
	logic [SUM_W-1:0]  prev_sum;
	logic [SUM_W-1:0]  acc_s1;

	logic              d_valid;
	logic [AVG_W-1:0]  d_quot;
	out_tag_t          d_tag;

	logic              out_valid_q;
	logic [AVG_W-1:0]  avg_q;
	out_tag_t          tag_q;

	// The whole back end moves together unless a result waits at the output
	assign adv   = !out_valid_q || res_ready;
	assign take  = adv && q_valid;
	assign q_pop = adv;

	// Sum the pixels of one block row
	assign hsum_new = (q_flags.col_first ? '0 : hsum_q) + HSUM_W'(q_pixel);

	always_ff @(posedge clk) begin
		if (take) begin
			hsum_q <= hsum_new;
		end
	end

	// Hand a finished block row to the accumulator stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= q_valid && q_flags.col_last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hsum_s1  <= hsum_new;
			col_s1   <= q_col;
			fresh_s1 <= q_flags.row_fresh;
			emit_s1  <= q_flags.row_last;
			tag_s1   <= '{frame_end: q_flags.frame_end, row_end: q_flags.row_end};
		end
	end

	// Read the column sum; bypass the write that lands on the same edge
	always_ff @(posedge clk) begin
		if (adv) begin
			rd_q  <= sums_mem[q_col];
			wr_q  <= acc_s1;
			fwd_q <= vld_s1 && (col_s1 == q_col);
		end
	end

	assign prev_sum = fwd_q ? wr_q : rd_q;
	assign acc_s1   = (fresh_s1 ? '0 : prev_sum) + SUM_W'(hsum_s1);

	// Write the updated column sum back
	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			sums_mem[col_s1] <= acc_s1;
		end
	end

	bxavg_div #(
		.SUM_W (SUM_W),
		.DIV_W (DIV_W),
		.QW    (AVG_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s1 && emit_s1),
		.dividend  (acc_s1),
		.divisor   (divisor),
		.in_tag    (tag_s1),
		.out_valid (d_valid),
		.quotient  (d_quot),
		.out_tag   (d_tag)
	);

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && d_valid) begin
			avg_q <= d_quot;
			tag_q <= d_tag;
		end
	end

	assign res_valid = out_valid_q;
	assign res_avg   = avg_q;
	assign res_tag   = tag_q;

endmodule

// ===== rtl/core/box_average_downscaler_unit.sv =====
// Top level of the box-average downscaler: front end, queue and back end.
// Depends on bxavg_pkg, bxavg_front, bxavg_queue and bxavg_back.
//
//   channel   direction  handshake            contents
//   s_*       in         s_tvalid / s_tready  tdata[7:0] pixel
//   m_*       out        m_tvalid / m_tready  tdata[7:0] average, tlast end_of_row,
//                                             tuser[0] end_of_frame
//   cfg_*     in         cfg_we               cfg_index selects register, cfg_data value
//
// One pixel per clock sustained while m_tready stays high. After the edge that accepts
// the bottom-right pixel of its block, the result leaves the queue with the memory read,
// passes nine divider registers that take the accumulated sum, and then the output
// register, whose output is m_tvalid.
// Reset clears control state only; the line accumulator needs no clearing pass,
// since every block sum restarts on the top row of its block.
// A stalled output freezes the back end; the front keeps taking words until
// the four-entry queue fills, then drops s_tready.
module box_average_downscaler_unit #(
	parameter int MAX_WIDTH  = bxavg_pkg::MAX_WIDTH_DEF,
	parameter int MAX_FACTOR = bxavg_pkg::MAX_FACTOR_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bxavg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bxavg_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bxavg_pkg::PIX_W-1:0]      s_tdata,   // [7:0] pixel
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bxavg_pkg::AVG_W-1:0]      m_tdata,   // [7:0] average
	output logic                             m_tlast,   // end_of_row
	output logic                             m_tuser    // [0] end_of_frame
);
	import bxavg_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int DIV_W  = 2 * $clog2(MAX_FACTOR + 1);
	localparam int FLG_W  = $bits(cmd_flags_t);
	localparam int QD_W   = COL_W + PIX_W + FLG_W;

	logic              push;
	logic [PIX_W-1:0]  push_pixel;
	logic [COL_W-1:0]  push_col;
	cmd_flags_t        push_flags;
	logic              q_full;
	logic [DIV_W-1:0]  divisor;

	logic              q_pop;
	logic              q_valid;
	logic [QD_W-1:0]   q_data;
	logic [PIX_W-1:0]  q_pixel;
	logic [COL_W-1:0]  q_col;
	cmd_flags_t        q_flags;
	out_tag_t          res_tag;

	bxavg_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_FACTOR (MAX_FACTOR)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pix_valid  (s_tvalid),
		.pix_ready  (s_tready),
		.pixel      (s_tdata),
		.q_full     (q_full),
		.push       (push),
		.push_pixel (push_pixel),
		.push_col   (push_col),
		.push_flags (push_flags),
		.divisor    (divisor)
	);

	bxavg_queue #(
		.DATA_W (QD_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_col, push_pixel, push_flags}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_data)
	);

	// Unpack the queue head
	assign q_flags = cmd_flags_t'(q_data[FLG_W-1:0]);
	assign q_pixel = q_data[FLG_W +: PIX_W];
	assign q_col   = q_data[FLG_W + PIX_W +: COL_W];

	bxavg_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_FACTOR (MAX_FACTOR)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pixel   (q_pixel),
		.q_col     (q_col),
		.q_flags   (q_flags),
		.q_pop     (q_pop),
		.divisor   (divisor),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_avg   (m_tdata),
		.res_tag   (res_tag)
	);

	assign m_tlast = res_tag.row_end;
	assign m_tuser = res_tag.frame_end;

endmodule

// ===== rtl/core/bxavg_checker.sv =====
// Port-level checks for the box-average downscaler, bound to the top level.
// Depends on bxavg_pkg and box_average_downscaler_unit.
module bxavg_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [bxavg_pkg::AVG_W-1:0] m_tdata,
	input logic                        m_tlast,
	input logic                        m_tuser
);
	import bxavg_pkg::*;

	// End of frame only comes with end of row
	a_frame_on_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("end_of_frame without end_of_row");

	// Hold a stalled result word
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result word changed while stalled");

	// Reset leaves no result pending
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result valid right after reset");

	// An idle output drains the queue, so input is open the cycle after
	a_queue_drains: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |=> s_tready)
		else $error("input blocked although the output was free");

endmodule

bind box_average_downscaler_unit bxavg_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
